// ===== hw/rtl/csmaca_pkg.sv =====
// Shared types, widths and codes of the CSMA/CA backoff contention engine.
package csmaca_pkg;

    localparam int TIME_BITS = 48;
    localparam int CW_BITS   = 10;
    localparam int SLOT_W    = 16;
    localparam int DRAW_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int WAIT_W  = CW_BITS + SLOT_W + 1;
    localparam int ACC_W   = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;
    localparam int DVS_W   = (CW_BITS + 1 > SLOT_W) ? CW_BITS + 1 : SLOT_W;
    localparam int ALU_W   = (ACC_W > DVS_W + 1) ? ACC_W : DVS_W + 1;
    localparam int CNT_W   = $clog2(TIME_BITS + 1);
    localparam int IN_W    = ((TIME_BITS + 1 + CW_BITS + DRAW_W + 7) / 8) * 8;
    localparam int OUT_W   = ((TIME_BITS + 6 + 7) / 8) * 8;

    localparam logic [SLOT_W-1:0] IFS_RESET  = 16'd34;
    localparam logic [SLOT_W-1:0] EIFS_RESET = 16'd94;
    localparam logic [SLOT_W-1:0] SLOT_RESET = 16'd9;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [WAIT_W-1:0]    t_wait;
    typedef logic [ACC_W-1:0]     t_acc;
    typedef logic [DVS_W-1:0]     t_dvs;
    typedef logic [ALU_W-1:0]     t_alu;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [1:0] {
        CTL_IDLE    = 2'd0,
        CTL_DEFER   = 2'd1,
        CTL_BACKOFF = 2'd2
    } t_ctl;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_MEDIUM  = 2'd1,
        REQ_CORRUPT = 2'd2,
        REQ_TICK    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NEW    = 2'd1,
        ACT_CANCEL = 2'd2
    } t_act;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IFS  = 2'd0,
        CFG_EIFS = 2'd1,
        CFG_SLOT = 2'd2,
        CFG_OPT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_DISP,
        SQ_DIV,
        SQ_MODEND,
        SQ_EIFS,
        SQ_SUMIFS,
        SQ_CMPEIFS,
        SQ_MUL,
        SQ_ADDW,
        SQ_EF,
        SQ_EFMIN,
        SQ_EI,
        SQ_EIMIN,
        SQ_SUBD,
        SQ_ACC,
        SQ_REM,
        SQ_CEIL,
        SQ_SHRINK,
        SQ_TICK,
        SQ_DONE
    } t_seq;

endpackage

// ===== hw/rtl/csma_ca_backoff_contention.sv =====
// Top level of the CSMA/CA backoff contention engine: sequencer around one shared add/sub unit.
//
// Usage: each event enters as one transfer on the slave stream (kind of event in
// s_axis_tuser, time and arguments in s_axis_tdata) and yields exactly one result
// transfer on the master stream (control state after the event, grant flag,
// expectation action, scheduled access time, error flag).
// The user writes timing registers through the plain write port between events;
// the block itself does not enforce it. All time arithmetic of the events runs
// through a single (ALU_W)-bit adder/subtractor: saturating time sums, compares,
// one bit per cycle of the restoring divider (draw mod window, remaining time over
// slot length) and one bit per cycle of the shift-add slot multiplier. s_axis_tready
// is high only while the sequencer waits for an event, so one event is in flight at a time.
// Steps per event: a start with free medium divides the draw by the window, adds
// IFS or EIFS, multiplies the backoff by the slot length and forms the access time;
// medium busy during backoff divides the remaining time by the slot length; ticks
// take one compare; the remaining-slots divide sets the longest path.
// The result sits in an output register; the next event is accepted while it
// waits. If m_axis_tready stays low, the following result holds in the last
// sequencer step until the register frees.
// Reset (synchronous, active low) returns to idle, medium free, no stamps seen,
// and loads the default IFS, EIFS, slot length and idle-time optimization.
module csma_ca_backoff_contention (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_time, medium_free, contention_window, random_draw (from bit 0 up)
    input  logic [csmaca_pkg::IN_W-1:0]     s_axis_tdata,
    // req_type
    input  logic [1:0]                      s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fsm_state, access_granted, expect_action, expected_time, event_error
    output logic [csmaca_pkg::OUT_W-1:0]    m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [csmaca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [csmaca_pkg::SLOT_W-1:0]   i_cfg_data
);
    import csmaca_pkg::*;

    // configuration
    logic [SLOT_W-1:0] r_ifs, r_eifs, r_slot;
    logic              r_opt;

    // architectural state
    t_ctl              r_ctl, n_ctl;
    logic              r_mfree, n_mfree;
    logic [CW_BITS-1:0] r_backoff, n_backoff;
    t_time             r_eifs_end, n_eifs_end;
    t_time             r_access, n_access;
    logic              r_pending, n_pending;
    t_time             r_busy_t, n_busy_t;
    logic              r_busy_seen, n_busy_seen;
    t_time             r_idle_t, n_idle_t;
    logic              r_idle_seen, n_idle_seen;

    // event latch and working registers
    t_seq              r_seq, n_seq;
    t_req              r_req, n_req;
    t_time             r_now, n_now;
    logic              r_in_free, n_in_free;
    t_time             r_quo, n_quo;
    t_dvs              r_rem, n_rem;
    t_dvs              r_dvs, n_dvs;
    t_acc              r_acc, n_acc;
    t_wait             r_wait, n_wait;
    t_wait             r_d, n_d;
    t_cnt              r_cnt, n_cnt;
    logic              r_flag, n_flag;
    logic              r_div_ceil, n_div_ceil;
    logic              r_from_idle, n_from_idle;

    // result being built and output register
    logic              r_grant, n_grant;
    t_act              r_act, n_act;
    logic              r_err, n_err;
    logic              r_ovalid, n_ovalid;
    logic [OUT_W-1:0]  r_odata, n_odata;

    // shared arithmetic unit
    t_alu              alu_a, alu_b;
    logic              alu_sub;
    logic [ALU_W:0]    alu_sum;
    t_alu              alu_res;
    logic              alu_c;
    logic              alu_hi;
    t_time             alu_sat;

    // unpacked input fields
    t_time              in_now;
    logic               in_free;
    logic [CW_BITS-1:0] in_cw;
    logic [DRAW_W-1:0]  in_draw;
    logic               in_xfer;

    assign in_now  = s_axis_tdata[TIME_BITS-1:0];
    assign in_free = s_axis_tdata[TIME_BITS];
    assign in_cw   = s_axis_tdata[TIME_BITS+CW_BITS:TIME_BITS+1];
    assign in_draw = s_axis_tdata[TIME_BITS+CW_BITS+DRAW_W:TIME_BITS+CW_BITS+1];

    assign s_axis_tready = (r_seq == SQ_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Operand selection for the shared adder; subtraction gives compares via carry.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_seq) inside
            SQ_DIV: begin
                alu_a   = t_alu'({r_rem, r_quo[TIME_BITS-1]});
                alu_b   = t_alu'(r_dvs);
                alu_sub = 1'b1;
            end
            SQ_MUL: begin
                alu_a = t_alu'({r_acc[ACC_W-2:0], 1'b0});
                alu_b = r_quo[TIME_BITS-1] ? t_alu'(r_slot) : '0;
            end
            SQ_SUMIFS: begin
                alu_a = t_alu'(r_now);
                alu_b = t_alu'(r_ifs);
            end
            SQ_EIFS: begin
                alu_a = t_alu'(r_now);
                alu_b = t_alu'(r_eifs);
            end
            SQ_CMPEIFS: begin
                alu_a   = t_alu'(r_acc);
                alu_b   = t_alu'(r_eifs_end);
                alu_sub = 1'b1;
            end
            SQ_ADDW: begin
                alu_a = t_alu'(r_wait);
                alu_b = t_alu'(r_acc);
            end
            SQ_EF: begin
                alu_a   = t_alu'(r_now);
                alu_b   = t_alu'(r_busy_t);
                alu_sub = 1'b1;
            end
            SQ_EI: begin
                alu_a   = t_alu'(r_now);
                alu_b   = t_alu'(r_idle_t);
                alu_sub = 1'b1;
            end
            SQ_EFMIN, SQ_EIMIN: begin
                alu_a   = t_alu'(r_acc);
                alu_b   = t_alu'(r_d);
                alu_sub = 1'b1;
            end
            SQ_SUBD: begin
                alu_a   = t_alu'(r_wait);
                alu_b   = t_alu'(r_d);
                alu_sub = 1'b1;
            end
            SQ_ACC: begin
                alu_a = t_alu'(r_now);
                alu_b = t_alu'(r_wait);
            end
            SQ_REM: begin
                alu_a   = t_alu'(r_access);
                alu_b   = t_alu'(r_now);
                alu_sub = 1'b1;
            end
            SQ_CEIL: begin
                alu_a = t_alu'(r_quo);
                alu_b = t_alu'(r_rem != '0);
            end
            SQ_SHRINK: begin
                alu_a   = t_alu'(r_acc);
                alu_b   = t_alu'(r_backoff);
                alu_sub = 1'b1;
            end
            SQ_TICK: begin
                alu_a   = t_alu'(r_now);
                alu_b   = t_alu'(r_access);
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // carry out of a subtraction means a >= b; for sums, bits above the time width saturate
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (ALU_W + 1)'(alu_sub);
    assign alu_res = alu_sum[ALU_W-1:0];
    assign alu_c   = alu_sum[ALU_W];
    assign alu_hi  = |alu_sum[ALU_W:TIME_BITS];
    assign alu_sat = alu_hi ? '1 : alu_res[TIME_BITS-1:0];

    // Sequencer next state.
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: begin
                if (in_xfer) n_seq = SQ_DISP;
            end
            SQ_DISP: begin
                unique case (r_req)
                    REQ_START:   n_seq = (r_ctl == CTL_IDLE) ? SQ_DIV : SQ_DONE;
                    REQ_MEDIUM: begin
                        if (r_ctl == CTL_DEFER && r_in_free) begin
                            n_seq = SQ_SUMIFS;
                        end else if (r_ctl == CTL_BACKOFF && !r_in_free && r_slot != '0) begin
                            n_seq = SQ_REM;
                        end else begin
                            n_seq = SQ_DONE;
                        end
                    end
                    REQ_CORRUPT: n_seq = (r_ctl != CTL_IDLE) ? SQ_EIFS : SQ_DONE;
                    REQ_TICK: begin
                        n_seq = (r_ctl == CTL_BACKOFF && r_pending) ? SQ_TICK : SQ_DONE;
                    end
                    default:     n_seq = SQ_DONE;
                endcase
            end
            SQ_DIV: begin
                if (r_cnt == t_cnt'(1)) n_seq = r_div_ceil ? SQ_CEIL : SQ_MODEND;
            end
            SQ_MODEND:  n_seq = r_mfree ? SQ_SUMIFS : SQ_DONE;
            SQ_EIFS:    n_seq = (r_ctl == CTL_BACKOFF) ? SQ_SUMIFS : SQ_DONE;
            SQ_SUMIFS:  n_seq = SQ_CMPEIFS;
            SQ_CMPEIFS: n_seq = SQ_MUL;
            SQ_MUL: begin
                if (r_cnt == t_cnt'(1)) n_seq = SQ_ADDW;
            end
            SQ_ADDW:    n_seq = (r_from_idle && r_opt) ? SQ_EF : SQ_ACC;
            SQ_EF:      n_seq = r_busy_seen ? SQ_EFMIN : SQ_EI;
            SQ_EFMIN:   n_seq = SQ_EI;
            SQ_EI:      n_seq = r_idle_seen ? SQ_EIMIN : SQ_SUBD;
            SQ_EIMIN:   n_seq = SQ_SUBD;
            SQ_SUBD:    n_seq = SQ_ACC;
            SQ_ACC:     n_seq = SQ_DONE;
            SQ_REM:     n_seq = SQ_DIV;
            SQ_CEIL:    n_seq = SQ_SHRINK;
            SQ_SHRINK:  n_seq = SQ_DONE;
            SQ_TICK:    n_seq = SQ_DONE;
            SQ_DONE: begin
                if (!r_ovalid || m_axis_tready) n_seq = SQ_IDLE;
            end
            default:    n_seq = SQ_IDLE;
        endcase
    end

    // Sequencer actions on the datapath and state registers.
    always_comb begin
        n_ctl       = r_ctl;
        n_mfree     = r_mfree;
        n_backoff   = r_backoff;
        n_eifs_end  = r_eifs_end;
        n_access    = r_access;
        n_pending   = r_pending;
        n_busy_t    = r_busy_t;
        n_busy_seen = r_busy_seen;
        n_idle_t    = r_idle_t;
        n_idle_seen = r_idle_seen;
        n_req       = r_req;
        n_now       = r_now;
        n_in_free   = r_in_free;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_acc       = r_acc;
        n_wait      = r_wait;
        n_d         = r_d;
        n_cnt       = r_cnt;
        n_flag      = r_flag;
        n_div_ceil  = r_div_ceil;
        n_from_idle = r_from_idle;
        n_grant     = r_grant;
        n_act       = r_act;
        n_err       = r_err;
        n_odata     = r_odata;
        n_ovalid    = r_ovalid && !m_axis_tready;

        unique case (r_seq)
            SQ_IDLE: begin
                if (in_xfer) begin
                    n_req       = t_req'(s_axis_tuser);
                    n_now       = in_now;
                    n_in_free   = in_free;
                    n_quo       = t_time'(in_draw) << (TIME_BITS - DRAW_W);
                    n_dvs       = t_dvs'(in_cw) + t_dvs'(1);
                    n_grant     = 1'b0;
                    n_act       = ACT_NONE;
                    n_err       = 1'b0;
                    n_from_idle = 1'b0;
                end
            end
            SQ_DISP: begin
                unique case (r_req)
                    REQ_START: begin
                        if (r_ctl != CTL_IDLE) begin
                            n_err = 1'b1;
                        end else begin
                            n_rem       = '0;
                            n_cnt       = t_cnt'(DRAW_W);
                            n_div_ceil  = 1'b0;
                            n_from_idle = 1'b1;
                        end
                    end
                    REQ_MEDIUM: begin
                        // medium bookkeeping happens in every state, errors included
                        n_mfree     = r_in_free;
                        n_busy_t    = r_now;
                        n_busy_seen = 1'b1;
                        if (r_ctl == CTL_DEFER) begin
                            if (!r_in_free) n_err = 1'b1;
                        end else if (r_ctl == CTL_BACKOFF) begin
                            if (!r_in_free) begin
                                n_pending = 1'b0;
                                n_ctl     = CTL_DEFER;
                                n_act     = ACT_CANCEL;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            SQ_DIV: begin
                // one restoring step: subtract when the trial remainder allows it
                n_quo = {r_quo[TIME_BITS-2:0], alu_c};
                n_rem = alu_c ? alu_res[DVS_W-1:0] : {r_rem[DVS_W-2:0], r_quo[TIME_BITS-1]};
                n_cnt = r_cnt - t_cnt'(1);
            end
            SQ_MODEND: begin
                n_backoff = r_rem[CW_BITS-1:0];
                if (!r_mfree) n_ctl = CTL_DEFER;
            end
            SQ_EIFS: begin
                n_eifs_end = alu_sat;
            end
            SQ_SUMIFS: begin
                n_acc = t_acc'(alu_sat);
            end
            SQ_CMPEIFS: begin
                // EIFS applies while its end lies beyond now + IFS
                n_wait = alu_c ? t_wait'(r_ifs) : t_wait'(r_eifs);
                n_acc  = '0;
                n_quo  = t_time'(r_backoff) << (TIME_BITS - CW_BITS);
                n_cnt  = t_cnt'(CW_BITS);
            end
            SQ_MUL: begin
                n_acc = t_acc'(alu_res);
                n_quo = r_quo << 1;
                n_cnt = r_cnt - t_cnt'(1);
            end
            SQ_ADDW: begin
                n_wait = alu_res[WAIT_W-1:0];
                n_d    = alu_res[WAIT_W-1:0];
            end
            SQ_EF: begin
                if (r_busy_seen) n_acc = alu_c ? t_acc'(alu_res[TIME_BITS-1:0]) : '0;
            end
            SQ_EI: begin
                if (r_idle_seen) n_acc = alu_c ? t_acc'(alu_res[TIME_BITS-1:0]) : '0;
            end
            SQ_EFMIN, SQ_EIMIN: begin
                if (!alu_c) n_d = r_acc[WAIT_W-1:0];
            end
            SQ_SUBD: begin
                n_wait = alu_res[WAIT_W-1:0];
            end
            SQ_ACC: begin
                n_access  = alu_sat;
                n_pending = 1'b1;
                n_act     = ACT_NEW;
                n_ctl     = CTL_BACKOFF;
            end
            SQ_REM: begin
                // remaining time, zero once the access time has passed
                n_quo      = alu_c ? alu_res[TIME_BITS-1:0] : '0;
                n_rem      = '0;
                n_dvs      = t_dvs'(r_slot);
                n_cnt      = t_cnt'(TIME_BITS);
                n_div_ceil = 1'b1;
            end
            SQ_CEIL: begin
                n_acc  = t_acc'(alu_res[TIME_BITS-1:0]);
                n_flag = alu_hi;
            end
            SQ_SHRINK: begin
                if (!r_flag && !alu_c) n_backoff = r_acc[CW_BITS-1:0];
            end
            SQ_TICK: begin
                if (alu_c) begin
                    n_pending   = 1'b0;
                    n_idle_t    = r_now;
                    n_idle_seen = 1'b1;
                    n_ctl       = CTL_IDLE;
                    n_grant     = 1'b1;
                end
            end
            SQ_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = OUT_W'({r_err,
                                       ((r_act == ACT_NEW) ? r_access : t_time'(0)),
                                       r_act, r_grant, r_ctl});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_ctl       <= CTL_IDLE;
            r_mfree     <= 1'b1;
            r_backoff   <= '0;
            r_eifs_end  <= '0;
            r_access    <= '0;
            r_pending   <= 1'b0;
            r_busy_t    <= '0;
            r_busy_seen <= 1'b0;
            r_idle_t    <= '0;
            r_idle_seen <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_ctl       <= n_ctl;
            r_mfree     <= n_mfree;
            r_backoff   <= n_backoff;
            r_eifs_end  <= n_eifs_end;
            r_access    <= n_access;
            r_pending   <= n_pending;
            r_busy_t    <= n_busy_t;
            r_busy_seen <= n_busy_seen;
            r_idle_t    <= n_idle_t;
            r_idle_seen <= n_idle_seen;
            r_ovalid    <= n_ovalid;
        end
    end

    // working registers and result payload need no reset
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_now       <= n_now;
        r_in_free   <= n_in_free;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_acc       <= n_acc;
        r_wait      <= n_wait;
        r_d         <= n_d;
        r_cnt       <= n_cnt;
        r_flag      <= n_flag;
        r_div_ceil  <= n_div_ceil;
        r_from_idle <= n_from_idle;
        r_grant     <= n_grant;
        r_act       <= n_act;
        r_err       <= n_err;
        r_odata     <= n_odata;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ifs  <= IFS_RESET;
            r_eifs <= EIFS_RESET;
            r_slot <= SLOT_RESET;
            r_opt  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IFS:  r_ifs  <= i_cfg_data;
                CFG_EIFS: r_eifs <= i_cfg_data;
                CFG_SLOT: r_slot <= i_cfg_data;
                CFG_OPT:  r_opt  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule
